// ===== hw/rtl/tmv_pkg.sv =====
package tmv_pkg;

    // Sizing of the name stack and of one packed tag name.
    localparam int MAX_DEPTH    = 16;
    localparam int MAX_NAME_LEN = 9;

    localparam int CHAR_W   = 8;
    localparam int LEN_W    = 4;
    localparam int LETTER_W = 5;
    localparam int NAME_W   = LEN_W + LETTER_W * MAX_NAME_LEN;
    localparam int DEPTH_W  = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int MI_W     = 4;
    localparam int BR_W     = 2;

    // Characters that steer the parser.
    localparam logic [CHAR_W-1:0] CH_LT     = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_GT     = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_BANG   = 8'h21;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_A      = 8'h41;
    localparam logic [CHAR_W-1:0] CH_Z      = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;

    // Index of the final character of the "[CDATA[" header.
    localparam logic [MI_W-1:0] CDATA_LAST = 4'd6;
    // Number of closing brackets that arm the end of a CDATA section.
    localparam logic [BR_W-1:0] BR_FULL    = 2'd2;

    typedef enum logic [7:0] {
        PH_START      = 8'b0000_0001,
        PH_OPEN_NAME  = 8'b0000_0010,
        PH_CONTENT    = 8'b0000_0100,
        PH_LT         = 8'b0000_1000,
        PH_CDATA_HDR  = 8'b0001_0000,
        PH_CDATA_BODY = 8'b0010_0000,
        PH_CLOSE_NAME = 8'b0100_0000,
        PH_DONE       = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic depth_overflow;
        logic valid_res;
    } t_result;

    // Expected character of the CDATA header at a given position.
    function automatic logic [CHAR_W-1:0] cdata_char(input logic [2:0] idx);
        logic [CHAR_W-1:0] ch;
        case (idx)
            3'd0:    ch = 8'h5B;
            3'd1:    ch = 8'h43;
            3'd2:    ch = 8'h44;
            3'd3:    ch = 8'h41;
            3'd4:    ch = 8'h54;
            3'd5:    ch = 8'h41;
            default: ch = 8'h5B;
        endcase
        return ch;
    endfunction

    // Appends one letter (0..25) to a packed name and bumps its length.
    function automatic logic [NAME_W-1:0] name_add(input logic [NAME_W-1:0] name,
                                                    input logic [LEN_W-1:0] len,
                                                    input logic [LETTER_W-1:0] letter);
        logic [NAME_W-1:0] res;
        res = name;
        for (int k = 0; k < MAX_NAME_LEN; k++) begin
            if (len == LEN_W'(k)) begin
                res[LEN_W + LETTER_W * k +: LETTER_W] = letter;
            end
        end
        res[LEN_W-1:0] = len + 1'b1;
        return res;
    endfunction

    // Letter at a given position of a packed name.
    function automatic logic [LETTER_W-1:0] name_letter(input logic [NAME_W-1:0] name,
                                                         input logic [MI_W-1:0] pos);
        logic [LETTER_W-1:0] res;
        res = '0;
        for (int k = 0; k < MAX_NAME_LEN; k++) begin
            if (pos == MI_W'(k)) begin
                res = name[LEN_W + LETTER_W * k +: LETTER_W];
            end
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/tmv_name_stack.sv =====
module tmv_name_stack (
    input  logic                                i_clk,
    input  logic                                i_wr_en,
    input  logic [tmv_pkg::IDX_W-1:0]           i_wr_idx,
    input  logic [tmv_pkg::NAME_W-1:0]          i_wr_name,
    input  logic [tmv_pkg::IDX_W-1:0]           i_rd_idx,
    output logic [tmv_pkg::NAME_W-1:0]          o_rd_name
);

    // Entries hold no reset value; each one is pushed before it is read.
    logic [tmv_pkg::NAME_W-1:0] r_names [tmv_pkg::MAX_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_names[i_wr_idx] <= i_wr_name;
        end
    end

    assign o_rd_name = r_names[i_rd_idx];

endmodule

// ===== hw/rtl/tmv_parser.sv =====
module tmv_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [tmv_pkg::CHAR_W-1:0]    i_char,
    input  logic                          i_last,
    output logic                          o_res_strobe,
    output tmv_pkg::t_result              o_res
);

    tmv_pkg::t_phase                r_phase, n_phase;
    logic [tmv_pkg::DEPTH_W-1:0]    r_depth, n_depth;
    logic [tmv_pkg::NAME_W-1:0]     r_cur, n_cur;
    logic [tmv_pkg::MI_W-1:0]       r_mi, n_mi;
    logic [tmv_pkg::BR_W-1:0]       r_br, n_br;
    logic                           r_err, n_err;
    logic                           r_ovf, n_ovf;

    logic                           push;
    logic                           do_open;
    logic [tmv_pkg::NAME_W-1:0]     cur_base;
    logic [tmv_pkg::LEN_W-1:0]      cur_len;
    logic                           is_upper;
    logic [tmv_pkg::CHAR_W-1:0]     letter_full;
    logic [tmv_pkg::DEPTH_W-1:0]    depth_m1;
    logic [tmv_pkg::NAME_W-1:0]     top_name;
    logic [tmv_pkg::LEN_W-1:0]      top_len;
    logic [tmv_pkg::CHAR_W-1:0]     want_char;

    tmv_name_stack u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (i_step && push),
        .i_wr_idx  (r_depth[tmv_pkg::IDX_W-1:0]),
        .i_wr_name (cur_base),
        .i_rd_idx  (depth_m1[tmv_pkg::IDX_W-1:0]),
        .o_rd_name (top_name)
    );

    // A name that starts right after a '<' in content begins empty.
    assign cur_base    = (r_phase == tmv_pkg::PH_LT) ? '0 : r_cur;
    assign cur_len     = cur_base[tmv_pkg::LEN_W-1:0];
    assign is_upper    = (i_char >= tmv_pkg::CH_A) && (i_char <= tmv_pkg::CH_Z);
    assign letter_full = i_char - tmv_pkg::CH_A;
    assign depth_m1    = r_depth - 1'b1;
    assign top_len     = top_name[tmv_pkg::LEN_W-1:0];
    assign want_char   = tmv_pkg::CHAR_W'(tmv_pkg::name_letter(top_name, r_mi))
                         + tmv_pkg::CH_A;

    always_comb begin
        n_phase = r_phase;
        n_depth = r_depth;
        n_cur   = r_cur;
        n_mi    = r_mi;
        n_br    = r_br;
        n_err   = r_err;
        n_ovf   = r_ovf;
        push    = 1'b0;
        do_open = 1'b0;

        if (!r_err) begin
            unique case (r_phase)
                tmv_pkg::PH_START: begin
                    if (i_char == tmv_pkg::CH_LT) begin
                        n_cur   = '0;
                        n_phase = tmv_pkg::PH_OPEN_NAME;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                tmv_pkg::PH_OPEN_NAME: begin
                    do_open = 1'b1;
                end
                tmv_pkg::PH_CONTENT: begin
                    if (i_char == tmv_pkg::CH_LT) begin
                        n_phase = tmv_pkg::PH_LT;
                    end
                end
                tmv_pkg::PH_LT: begin
                    if (i_char == tmv_pkg::CH_BANG) begin
                        n_mi    = '0;
                        n_phase = tmv_pkg::PH_CDATA_HDR;
                    end else if (i_char == tmv_pkg::CH_SLASH) begin
                        n_mi    = '0;
                        n_phase = tmv_pkg::PH_CLOSE_NAME;
                    end else begin
                        n_cur   = '0;
                        do_open = 1'b1;
                    end
                end
                tmv_pkg::PH_CDATA_HDR: begin
                    if ((r_mi > tmv_pkg::CDATA_LAST) ||
                        (i_char != tmv_pkg::cdata_char(r_mi[2:0]))) begin
                        n_err = 1'b1;
                    end else if (r_mi == tmv_pkg::CDATA_LAST) begin
                        n_br    = '0;
                        n_phase = tmv_pkg::PH_CDATA_BODY;
                    end else begin
                        n_mi = r_mi + 1'b1;
                    end
                end
                tmv_pkg::PH_CDATA_BODY: begin
                    if (i_char == tmv_pkg::CH_RBRACK) begin
                        if (r_br < tmv_pkg::BR_FULL) begin
                            n_br = r_br + 1'b1;
                        end
                    end else if ((i_char == tmv_pkg::CH_GT) && (r_br == tmv_pkg::BR_FULL)) begin
                        n_br    = '0;
                        n_phase = tmv_pkg::PH_CONTENT;
                    end else begin
                        n_br = '0;
                    end
                end
                tmv_pkg::PH_CLOSE_NAME: begin
                    if ((r_depth == '0) ||
                        (r_depth > tmv_pkg::DEPTH_W'(tmv_pkg::MAX_DEPTH))) begin
                        n_err = 1'b1;
                    end else if ((r_mi < tmv_pkg::MI_W'(top_len)) &&
                                 (r_mi < tmv_pkg::MI_W'(tmv_pkg::MAX_NAME_LEN))) begin
                        if (i_char != want_char) begin
                            n_err = 1'b1;
                        end else begin
                            n_mi = r_mi + 1'b1;
                        end
                    end else if (i_char == tmv_pkg::CH_GT) begin
                        n_depth = depth_m1;
                        n_phase = (depth_m1 == '0) ? tmv_pkg::PH_DONE : tmv_pkg::PH_CONTENT;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                tmv_pkg::PH_DONE: begin
                    n_err = 1'b1;
                end
                default: begin
                    n_err = 1'b1;
                end
            endcase

            // Shared handling of one byte of an opening tag name.
            if (do_open) begin
                if (is_upper) begin
                    if (cur_len >= tmv_pkg::LEN_W'(tmv_pkg::MAX_NAME_LEN)) begin
                        n_err = 1'b1;
                    end else begin
                        n_cur   = tmv_pkg::name_add(cur_base, cur_len,
                                                    letter_full[tmv_pkg::LETTER_W-1:0]);
                        n_phase = tmv_pkg::PH_OPEN_NAME;
                    end
                end else if ((i_char == tmv_pkg::CH_GT) && (cur_len != '0)) begin
                    if (r_depth >= tmv_pkg::DEPTH_W'(tmv_pkg::MAX_DEPTH)) begin
                        n_ovf = 1'b1;
                        n_err = 1'b1;
                    end else begin
                        push    = 1'b1;
                        n_depth = r_depth + 1'b1;
                        n_phase = tmv_pkg::PH_CONTENT;
                    end
                end else begin
                    n_err = 1'b1;
                end
            end
        end
    end

    assign o_res_strobe         = i_step && i_last;
    assign o_res.valid_res      = !n_err && (n_phase == tmv_pkg::PH_DONE);
    assign o_res.depth_overflow = n_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_phase <= tmv_pkg::PH_START;
            r_depth <= '0;
            r_cur   <= '0;
            r_mi    <= '0;
            r_br    <= '0;
            r_err   <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_depth <= n_depth;
            r_cur   <= n_cur;
            r_mi    <= n_mi;
            r_br    <= n_br;
            r_err   <= n_err;
            r_ovf   <= n_ovf;
        end
    end

`ifndef ASSERT_OFF
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= tmv_pkg::DEPTH_W'(tmv_pkg::MAX_DEPTH))
        else $error("nesting depth past the stack size");

    a_ovf_is_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_err)
        else $error("overflow recorded without the error flag");

    a_done_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == tmv_pkg::PH_DONE) |-> (r_depth == '0))
        else $error("outer tag closed with names left on the stack");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && push) |-> (r_depth < tmv_pkg::DEPTH_W'(tmv_pkg::MAX_DEPTH)))
        else $error("push into a full name stack");
`endif

endmodule

// ===== hw/rtl/tag_markup_validator.sv =====
// Channel  | Direction | Ports                                 | Word contents (low bit up)
// ---------+-----------+---------------------------------------+-----------------------------
// s (in)   | input     | i_s_tvalid o_s_tready i_s_tdata/tlast | tdata[7:0] character,
//          |           |                                       | tlast = final byte of string
// m (out)  | output    | o_m_tvalid i_m_tready o_m_tdata       | [0] valid_res,
//          |           |                                       | [1] depth_overflow, [7:2] zero
//
// The block takes one character word per clock cycle, except while a final byte waits for a
// stalled output. A word sits in the input register while the parser checks it, comparing
// against the name stack top, and the parser state updates as the word steps on; the result
// of a final byte is loaded into the output register at the same edge as that update.
// Reset is synchronous and active low; it clears the parser and both handshake registers,
// while the name stack keeps whatever it holds. A stalled output stalls only a final byte:
// ordinary bytes of the next string keep flowing while a result waits in the output register.
module tag_markup_validator (
    input  logic       i_clk,
    input  logic       i_rst_n,

    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] character
    input  logic       i_s_tlast,   // last

    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata    // [0] valid_res, [1] depth_overflow, [7:2] zero
);

    // Input register holding one character word.
    logic                        r_in_valid;
    logic [tmv_pkg::CHAR_W-1:0]  r_in_char;
    logic                        r_in_last;

    // Output register holding one result word.
    logic                        r_out_valid;
    tmv_pkg::t_result            r_out_res;

    logic                        step;
    logic                        s_accept;
    logic                        res_strobe;
    tmv_pkg::t_result            res;

    // The held word moves into the parser unless it is a final byte and the result
    // register is still occupied by an untaken result.
    assign step       = r_in_valid && (!r_in_last || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || step;
    assign s_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_char <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    tmv_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_char       (r_in_char),
        .i_last       (r_in_last),
        .o_res_strobe (res_strobe),
        .o_res        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_strobe) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_strobe) begin
            r_out_res <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_out_res.depth_overflow, r_out_res.valid_res};

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !res_strobe)
        else $error("result written over an untaken result");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !step) |=> (r_in_valid && $stable(r_in_char) && $stable(r_in_last)))
        else $error("held character word lost or changed");

    a_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_strobe |-> (step && r_in_last))
        else $error("result produced for a byte that is not final");
`endif

endmodule

// ===== dv/tb_tag_markup_validator.sv =====
module tb_tag_markup_validator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 10;
    // The longest quiet stretch of a correct run is the long output hold plus a few idle
    // bursts, so this leaves a wide margin.
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;

    // Text of the CDATA opener after "<!", first character in the top byte.
    localparam logic [7*tmv_pkg::CHAR_W-1:0] CDATA_TAG = "[CDATA[";

    // One tag name as the predictor keeps it: a length and up to nine letters (0..25).
    typedef struct packed {
        logic [tmv_pkg::LEN_W-1:0]                           len;
        logic [tmv_pkg::LETTER_W*tmv_pkg::MAX_NAME_LEN-1:0]  letters;
    } t_tag_name;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata  = '0;    // [7:0] character
    logic       i_s_tlast  = 1'b0;  // last
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;          // [0] valid_res, [1] depth_overflow, [7:2] zero

    tag_markup_validator DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shared state of the sender, the receiver and the checker.
    tmv_pkg::t_result verdicts_due[$];  // verdicts still owed by the block, oldest first
    logic [7:0]  word_q[$];         // the string being built, one character per word
    int          mismatches   = 0;
    int          verdicts_seen = 0;
    int          words_sent   = 0;
    bit          source_gaps  = 1'b0;
    bit          sink_gaps    = 1'b0;
    int          hold_cycles  = 0;

    // Private copy of the parser state. The name stack is never cleared: an entry is
    // always pushed before a closing tag reads it.
    tmv_pkg::t_phase prs_phase;
    int unsigned prs_depth;
    t_tag_name   prs_stack[tmv_pkg::MAX_DEPTH];
    t_tag_name   prs_name;
    int unsigned prs_pos;
    logic [tmv_pkg::BR_W-1:0] prs_brackets;
    bit          prs_fault;
    bit          prs_overflow;

    //------------------------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------------------------

    function automatic void parser_clear();
        prs_phase    = tmv_pkg::PH_START;
        prs_depth    = 0;
        prs_name     = '0;
        prs_pos      = 0;
        prs_brackets = '0;
        prs_fault    = 1'b0;
        prs_overflow = 1'b0;
    endfunction

    // One character of an opening name, the '<' already seen. A '>' pushes the name,
    // unless the name is empty or the stack is already full.
    function automatic void take_name_char(input logic [7:0] c);
        if (c >= tmv_pkg::CH_A && c <= tmv_pkg::CH_Z) begin
            if (prs_name.len >= tmv_pkg::MAX_NAME_LEN) begin
                prs_fault = 1'b1;
            end else begin
                prs_name.letters[tmv_pkg::LETTER_W*prs_name.len +: tmv_pkg::LETTER_W] =
                    tmv_pkg::LETTER_W'(c - tmv_pkg::CH_A);
                prs_name.len = prs_name.len + 1'b1;
                prs_phase = tmv_pkg::PH_OPEN_NAME;
            end
        end else if (c == tmv_pkg::CH_GT && prs_name.len != 0) begin
            if (prs_depth >= tmv_pkg::MAX_DEPTH) begin
                prs_overflow = 1'b1;
                prs_fault    = 1'b1;
            end else begin
                prs_stack[prs_depth] = prs_name;
                prs_depth++;
                prs_phase = tmv_pkg::PH_CONTENT;
            end
        end else begin
            prs_fault = 1'b1;
        end
    endfunction

    // One character of a closing name: each letter must match the top of the stack,
    // and the '>' may only come once the whole name has matched.
    function automatic void take_close_char(input logic [7:0] c);
        t_tag_name top;
        if (prs_depth == 0) begin
            prs_fault = 1'b1;
            return;
        end
        top = prs_stack[prs_depth - 1];
        if (prs_pos < top.len) begin
            if (c != tmv_pkg::CH_A +
                     8'(top.letters[tmv_pkg::LETTER_W*prs_pos +: tmv_pkg::LETTER_W]))
                prs_fault = 1'b1;
            else
                prs_pos++;
        end else if (c == tmv_pkg::CH_GT) begin
            prs_depth--;
            prs_phase = (prs_depth == 0) ? tmv_pkg::PH_DONE : tmv_pkg::PH_CONTENT;
        end else begin
            prs_fault = 1'b1;
        end
    endfunction

    // Advances the private parser by one accepted word. Returns 1 when the word closes
    // a string, with the verdict the block owes for it.
    function automatic bit predict_verdict(input logic [7:0] c, input bit fin,
                                           output tmv_pkg::t_result v);
        v = '0;
        if (!prs_fault) begin
            case (prs_phase)
                tmv_pkg::PH_START: begin
                    if (c == tmv_pkg::CH_LT) begin
                        prs_name  = '0;
                        prs_phase = tmv_pkg::PH_OPEN_NAME;
                    end else begin
                        prs_fault = 1'b1;
                    end
                end
                tmv_pkg::PH_OPEN_NAME: take_name_char(c);
                tmv_pkg::PH_CONTENT: begin
                    if (c == tmv_pkg::CH_LT)
                        prs_phase = tmv_pkg::PH_LT;
                end
                tmv_pkg::PH_LT: begin
                    if (c == tmv_pkg::CH_BANG) begin
                        prs_pos   = 0;
                        prs_phase = tmv_pkg::PH_CDATA_HDR;
                    end else if (c == tmv_pkg::CH_SLASH) begin
                        prs_pos   = 0;
                        prs_phase = tmv_pkg::PH_CLOSE_NAME;
                    end else begin
                        prs_name = '0;
                        take_name_char(c);
                    end
                end
                tmv_pkg::PH_CDATA_HDR: begin
                    if (c != CDATA_TAG[tmv_pkg::CHAR_W*(tmv_pkg::CDATA_LAST - prs_pos)
                                       +: tmv_pkg::CHAR_W]) begin
                        prs_fault = 1'b1;
                    end else if (prs_pos == tmv_pkg::CDATA_LAST) begin
                        prs_brackets = '0;
                        prs_phase    = tmv_pkg::PH_CDATA_BODY;
                    end else begin
                        prs_pos++;
                    end
                end
                tmv_pkg::PH_CDATA_BODY: begin
                    // Only "]]>" ends a section; the bracket count saturates at two.
                    if (c == tmv_pkg::CH_RBRACK) begin
                        if (prs_brackets < tmv_pkg::BR_FULL)
                            prs_brackets++;
                    end else if (c == tmv_pkg::CH_GT && prs_brackets == tmv_pkg::BR_FULL) begin
                        prs_brackets = '0;
                        prs_phase    = tmv_pkg::PH_CONTENT;
                    end else begin
                        prs_brackets = '0;
                    end
                end
                tmv_pkg::PH_CLOSE_NAME: take_close_char(c);
                // Anything after the outer closing tag is a fault.
                default: prs_fault = 1'b1;
            endcase
        end
        if (!fin)
            return 1'b0;
        v.valid_res      = !prs_fault && prs_phase == tmv_pkg::PH_DONE;
        v.depth_overflow = prs_overflow;
        parser_clear();
        return 1'b1;
    endfunction

    //------------------------------------------------------------------------------------
    // String building
    //------------------------------------------------------------------------------------

    function automatic void put_text(input string s);
        for (int k = 0; k < s.len(); k++)
            word_q.push_back(s[k]);
    endfunction

    function automatic string random_name(input int unsigned n);
        string s;
        s = "";
        for (int k = 0; k < n; k++)
            s = $sformatf("%s%c", s, tmv_pkg::CH_A + 8'($urandom_range(0, 25)));
        return s;
    endfunction

    // Mostly short names, a fair share at full length, and, where faults are wanted,
    // now and then an empty or an overlong one.
    function automatic int unsigned pick_name_len(input bit allow_bad);
        if (allow_bad && $urandom_range(0, 5) == 0)
            return ($urandom_range(0, 1) == 1) ? tmv_pkg::MAX_NAME_LEN + 1 : 0;
        if ($urandom_range(0, 3) == 0)
            return tmv_pkg::MAX_NAME_LEN;
        return $urandom_range(1, 3);
    endfunction

    // Plain content: any byte but '<', which would start markup.
    function automatic void put_filler(input int unsigned n);
        logic [7:0] c;
        for (int k = 0; k < n; k++) begin
            c = 8'($urandom_range(0, 255));
            word_q.push_back((c == tmv_pkg::CH_LT) ? tmv_pkg::CH_GT : c);
        end
    endfunction

    // A CDATA section whose body is rich in ']' but never holds "]]>" early; a '>' that
    // would close it too soon is turned into a '<', which is harmless inside CDATA.
    function automatic void put_cdata();
        int unsigned run;
        logic [7:0]  c;
        run = 0;
        word_q.push_back(tmv_pkg::CH_LT);
        word_q.push_back(tmv_pkg::CH_BANG);
        for (int k = 0; k <= tmv_pkg::CDATA_LAST; k++)
            word_q.push_back(CDATA_TAG[tmv_pkg::CHAR_W*(tmv_pkg::CDATA_LAST - k)
                                       +: tmv_pkg::CHAR_W]);
        for (int k = $urandom_range(0, 10); k > 0; k--) begin
            c = ($urandom_range(0, 2) == 0) ? tmv_pkg::CH_RBRACK : 8'($urandom_range(0, 255));
            if (c == tmv_pkg::CH_GT && run >= 2)
                c = tmv_pkg::CH_LT;
            run = (c == tmv_pkg::CH_RBRACK) ? run + 1 : 0;
            word_q.push_back(c);
        end
        put_text("]]>");
    endfunction

    // One tag with random content, well formed unless bad_names is set, nested up to max_lvl
    // deep, growing to about budget characters before it starts closing.
    function automatic void build_tag(input int unsigned max_lvl, input int unsigned budget,
                                      input bit bad_names);
        string       opened[$];
        string       nm;
        int unsigned pick;
        word_q.delete();
        nm = random_name(pick_name_len(bad_names));
        put_text({"<", nm, ">"});
        opened.push_back(nm);
        while (opened.size() != 0) begin
            pick = $urandom_range(0, 9);
            if (word_q.size() < budget && pick <= 2) begin
                put_filler($urandom_range(1, 6));
            end else if (word_q.size() < budget && pick == 3) begin
                put_cdata();
            end else if (word_q.size() < budget && pick <= 6 && opened.size() < max_lvl) begin
                nm = random_name(pick_name_len(bad_names));
                put_text({"<", nm, ">"});
                opened.push_back(nm);
            end else begin
                nm = opened.pop_back();
                put_text({"</", nm, ">"});
            end
        end
    endfunction

    // Breaks a built string: a random byte, an early end, bytes after the outer tag, or
    // a letter swapped so that a closing name no longer matches.
    function automatic void damage_string();
        int unsigned idx;
        int unsigned keep;
        case ($urandom_range(0, 3))
            0: begin
                idx = $urandom_range(0, word_q.size() - 1);
                word_q[idx] = 8'($urandom_range(0, 255));
            end
            1: begin
                keep = $urandom_range(1, word_q.size() - 1);
                while (word_q.size() > keep)
                    void'(word_q.pop_back());
            end
            2: put_filler($urandom_range(1, 3));
            default: begin
                for (int tries = 0; tries < 8; tries++) begin
                    idx = $urandom_range(0, word_q.size() - 1);
                    if (word_q[idx] >= tmv_pkg::CH_A && word_q[idx] <= tmv_pkg::CH_Z) begin
                        word_q[idx] = tmv_pkg::CH_A + 8'($urandom_range(0, 25));
                        break;
                    end
                end
            end
        endcase
    endfunction

    // n nested tags with names of nlen letters. With lead_fault a mismatched closing
    // tag comes first, which must hide the overflow that follows.
    function automatic void build_nest(input int unsigned n, input int unsigned nlen,
                                       input bit lead_fault);
        string names[$];
        string nm;
        word_q.delete();
        if (lead_fault)
            put_text("<Q></R>");
        for (int k = 0; k < n; k++) begin
            nm = random_name(nlen);
            put_text({"<", nm, ">"});
            if ($urandom_range(0, 3) == 0)
                put_cdata();
            names.push_back(nm);
        end
        while (names.size() != 0) begin
            nm = names.pop_back();
            put_text({"</", nm, ">"});
        end
    endfunction

    //------------------------------------------------------------------------------------
    // Sender
    //------------------------------------------------------------------------------------

    // Offers one word, perhaps after an idle burst, and waits for the handshake. The
    // predictor runs on the edge that accepts the word.
    task automatic send_word(input logic [7:0] c, input bit fin);
        tmv_pkg::t_result v;
        if (source_gaps && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        i_s_tlast  <= fin;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        words_sent++;
        if (predict_verdict(c, fin, v))
            verdicts_due.push_back(v);
    endtask

    // Sends the built string, tlast on its final character.
    task automatic send_queued();
        for (int k = 0; k < word_q.size(); k++)
            send_word(word_q[k], k == word_q.size() - 1);
    endtask

    task automatic send_text(input string s);
        word_q.delete();
        put_text(s);
        send_queued();
    endtask

    // Drops tvalid and holds the sender until the block owes nothing.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (verdicts_due.size() != 0)
            @(posedge i_clk);
    endtask

    // A random string: most are well formed, some carry bad names, a quarter are damaged.
    task automatic send_random_string();
        build_tag($urandom_range(1, 4), $urandom_range(8, 60), $urandom_range(0, 7) == 0);
        if ($urandom_range(0, 3) == 0)
            damage_string();
        send_queued();
    endtask

    //------------------------------------------------------------------------------------
    // Receiver and checker
    //------------------------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns, verdict %0d: %s", $time, verdicts_seen, what);
        mismatches++;
    endtask

    task automatic check_verdict(input logic [7:0] word);
        tmv_pkg::t_result got;
        tmv_pkg::t_result want;
        got = word[1:0];
        if (verdicts_due.size() == 0) begin
            report_mismatch($sformatf("word %h arrived with no verdict owed", word));
        end else begin
            want = verdicts_due.pop_front();
            if (got.valid_res != want.valid_res)
                report_mismatch($sformatf("valid_res %0b, expected %0b",
                                          got.valid_res, want.valid_res));
            if (got.depth_overflow != want.depth_overflow)
                report_mismatch($sformatf("depth_overflow %0b, expected %0b",
                                          got.depth_overflow, want.depth_overflow));
            if (word[7:2] != '0)
                report_mismatch($sformatf("padding bits %b, expected zero", word[7:2]));
        end
        verdicts_seen++;
    endtask

    // Checks each accepted result word, then decides tready for the next cycle. A long
    // hold asked by a test is counted down here; otherwise idle bursts come at random
    // while sink_gaps is set.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready)
                check_verdict(o_m_tdata);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 13) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Ends the run when no word has moved on either side for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    //------------------------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------------------------

    // Short hand-picked strings: single-byte strings at both ends of the byte range,
    // the smallest valid tag, a mismatched close, an empty name, a ten-letter name,
    // a byte after the outer tag and a string that ends early.
    task automatic test_directed();
        source_gaps = 1'b0;
        sink_gaps   = 1'b0;
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b1);
        send_text("<A></A>");
        send_text("<Z></Y>");
        send_text("<>");
        send_text("<ABCDEFGHIJ>");
        send_text("<A></A>/");
        send_text("<B>");
        wait_drained();
    endtask

    // The stack filled exactly with full-length names, one level too many, an overflow
    // hidden behind an earlier fault, and one random depth around the limit.
    task automatic test_depth_limit();
        source_gaps = 1'b1;
        sink_gaps   = 1'b1;
        build_nest(tmv_pkg::MAX_DEPTH, tmv_pkg::MAX_NAME_LEN, 1'b0);
        send_queued();
        build_nest(tmv_pkg::MAX_DEPTH + 1, 1, 1'b0);
        send_queued();
        build_nest(tmv_pkg::MAX_DEPTH + 1, 2, 1'b1);
        send_queued();
        build_nest($urandom_range(tmv_pkg::MAX_DEPTH - 2, tmv_pkg::MAX_DEPTH + 1),
                   $urandom_range(1, tmv_pkg::MAX_NAME_LEN), 1'b0);
        send_queued();
        wait_drained();
    endtask

    // The main random mix. Idling on each side switches on and off per string so that
    // some stretches run with no gaps, and now and then the sender lets the block drain.
    task automatic test_random_strings();
        int start;
        start = words_sent;
        while (words_sent - start < 400) begin
            source_gaps = $urandom_range(0, 3) != 0;
            sink_gaps   = $urandom_range(0, 3) != 0;
            send_random_string();
            if ($urandom_range(0, 11) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while short strings keep coming, so the
    // output register fills and the block has to refuse a final character.
    task automatic test_output_stall();
        string nm;
        source_gaps = 1'b0;
        sink_gaps   = 1'b0;
        hold_cycles = HOLD_CYCLES;
        repeat (12) begin
            nm = random_name($urandom_range(1, 3));
            send_text({"<", nm, "></", nm, ">"});
        end
        wait_drained();
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_full_rate();
        int start;
        source_gaps = 1'b0;
        sink_gaps   = 1'b0;
        start = words_sent;
        while (words_sent - start < 150)
            send_random_string();
        wait_drained();
    endtask

    initial begin
        parser_clear();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_depth_limit();
        test_random_strings();
        test_output_stall();
        test_full_rate();

        // The closing wait catches any stray result that is still on its way.
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && verdicts_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/tmv_pkg.sv
hw/rtl/tmv_name_stack.sv
hw/rtl/tmv_parser.sv
hw/rtl/tag_markup_validator.sv
dv/tb_tag_markup_validator.sv
